// ----- rtl/prc_pkg.sv -----
// Constants and the arctangent table for the polar/rectangular CORDIC converter.
// Standalone package; used by polar_rect_converter.
`timescale 1ns / 1ps

package prc_pkg;

	// Fixed field widths of the angle ports.
	localparam int unsigned ANGLE_IN_W  = 17;
	localparam int unsigned ANGLE_OUT_W = 16;

	// Internal binary angle: 2^32 units per turn, kept in a signed word with headroom.
	localparam int unsigned ZW = 34;
	localparam logic signed [ZW-1:0] Z_HALF_TURN = 34'sd2147483648;
	localparam logic signed [ZW-1:0] Z_FULL_TURN = 34'sd4294967296;
	localparam logic [31:0] BA_QUARTER  = 32'd1073741824;
	localparam logic [31:0] BA_3QUARTER = 32'd3221225472;

	// Fraction bits given to coordinates before vectoring.
	localparam int unsigned VEC_FRAC = 16;

	// 1/K of the CORDIC gain in Q30.
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	// Degrees with 7 fraction bits: one turn, its multiples and a half turn.
	localparam logic [17:0] TURN_DEG7    = 18'd46080;
	localparam logic [17:0] TURN2_DEG7   = 18'd92160;
	localparam logic [17:0] TURN3_DEG7   = 18'd138240;
	localparam logic [15:0] TURN_MUL     = 16'd46080;
	localparam logic [14:0] HALF_TURN_DEG7 = 15'd23040;

	// Degrees to binary angle: floor((t*2^22 + 22) / 45), with
	// t*2^22 = 45*93206*t + 34*t, and the remaining /45 done by reciprocal.
	localparam logic [16:0] BA_MUL   = 17'd93206;
	localparam logic [5:0]  BA_REM   = 6'd34;
	localparam logic [4:0]  BA_RND   = 5'd22;
	localparam logic [21:0] DIV45_M  = 22'd2982617;

	// Rounding offsets for the output scaling.
	localparam logic [29:0] RND_Q30 = 30'd536870912;
	localparam logic [54:0] MAG_RND = 55'd35184372088832;
	localparam logic [49:0] ANG_RND = 50'd2147483648;

	// atan(2^-i) in binary angle units, rounded to nearest.
	function automatic logic [29:0] atan_f(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			5'd31: v = 30'd0;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/polar_rect_converter.sv -----
// Pipelined CORDIC converter between polar and rectangular coordinates.
// Depends on prc_pkg for constants and the arctangent table.
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid/in_ready): kind selects the conversion. Kind 0 takes
// magnitude_in and angle_in (degrees, 7 fraction bits) and returns x_out and
// y_out. Kind 1 takes x_in and y_in and returns magnitude_out and angle_out.
// Result fields that a kind does not produce read zero.
// Output channel (out_valid/out_ready): one result per transfer, in input order.
// From an input transfer to out_valid, an item passes the angle conversion and
// setup stages, one CORDIC micro-rotation per stage, and the output scaling
// and rounding stages into the output register. Throughput is one item per
// cycle while the receiver does not stall, set by the unrolled rotation stages.
// When the receiver stalls, the whole pipeline holds its contents; the first
// stage still takes a transfer while it is empty, so a bubble there is filled.
// Reset clears all valid bits; no result is presented until new input arrives.
module polar_rect_converter #(
	parameter int COORD_WIDTH = 16,
	parameter int ITERATIONS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   kind,
	input  logic signed [COORD_WIDTH-1:0]          x_in,
	input  logic signed [COORD_WIDTH-1:0]          y_in,
	input  logic        [COORD_WIDTH-2:0]          magnitude_in,
	input  logic signed [prc_pkg::ANGLE_IN_W-1:0]  angle_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [COORD_WIDTH-1:0]          x_out,
	output logic signed [COORD_WIDTH-1:0]          y_out,
	output logic        [COORD_WIDTH-1:0]          magnitude_out,
	output logic signed [prc_pkg::ANGLE_OUT_W-1:0] angle_out
);

	localparam int CW   = COORD_WIDTH;
	localparam int RW   = CW + 32;
	localparam int ZW   = prc_pkg::ZW;
	localparam int XRW  = CW + 29;
	localparam int MHW  = CW - 4;
	localparam int MHPW = MHW + 30;
	localparam int MSW  = MHPW + 1;
	localparam int QW   = CW + 3;
	localparam int AOW  = prc_pkg::ANGLE_OUT_W;

	localparam logic [QW-1:0] Q_POS_MAX = QW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [QW-1:0] Q_NEG_MAX = QW'(64'd1 << (CW - 1));
	localparam logic [CW-1:0] C_POS_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] C_NEG_MAX = {1'b1, {(CW-1){1'b0}}};

	logic en;

	// ---------------------------------------------------------------- stage 1
	logic                  v_s1, kind_s1, neg_s1, ypos_s1, org_s1;
	logic [15:0]           t_s1;
	logic [XRW-1:0]        xr_s1;
	logic signed [CW:0]    xv_s1, yv_s1;

	logic [17:0]           a_off_c, t_full_c;
	logic [XRW-1:0]        xr_c;
	logic signed [CW:0]    xv_c, yv_c;

	always_comb begin
		a_off_c = {angle_in[prc_pkg::ANGLE_IN_W-1], angle_in} + prc_pkg::TURN2_DEG7;
		if (a_off_c >= prc_pkg::TURN3_DEG7) begin
			t_full_c = a_off_c - prc_pkg::TURN3_DEG7;
		end else if (a_off_c >= prc_pkg::TURN2_DEG7) begin
			t_full_c = a_off_c - prc_pkg::TURN2_DEG7;
		end else if (a_off_c >= prc_pkg::TURN_DEG7) begin
			t_full_c = a_off_c - prc_pkg::TURN_DEG7;
		end else begin
			t_full_c = a_off_c;
		end
		xr_c = XRW'(magnitude_in) * XRW'(prc_pkg::INV_GAIN_Q30);
		// A point left of the y axis is turned by a half turn before vectoring.
		xv_c = x_in[CW-1] ? -((CW+1)'(x_in)) : (CW+1)'(x_in);
		yv_c = x_in[CW-1] ? -((CW+1)'(y_in)) : (CW+1)'(y_in);
	end

	assign in_ready = en || !v_s1;

	always_ff @(posedge clk) begin
		if (in_ready) begin
			kind_s1 <= kind;
			t_s1    <= t_full_c[15:0];
			xr_s1   <= xr_c;
			xv_s1   <= xv_c;
			yv_s1   <= yv_c;
			neg_s1  <= x_in[CW-1];
			ypos_s1 <= !y_in[CW-1];
			org_s1  <= (x_in == '0) && (y_in == '0);
		end
	end

	// ---------------------------------------------------------------- stage 2
	logic                  v_s2, kind_s2, neg_s2, ypos_s2, org_s2;
	logic [31:0]           p_s2;
	logic [15:0]           d_s2;
	logic [XRW-1:0]        xr_s2;
	logic signed [CW:0]    xv_s2, yv_s2;

	logic [32:0]           p_full_c;
	logic [20:0]           yy_c;
	logic [42:0]           dprod_c;

	always_comb begin
		p_full_c = 33'(t_s1) * 33'(prc_pkg::BA_MUL);
		yy_c     = 21'(t_s1) * 21'(prc_pkg::BA_REM) + 21'(prc_pkg::BA_RND);
		dprod_c  = 43'(yy_c) * 43'(prc_pkg::DIV45_M);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			p_s2    <= p_full_c[31:0];
			d_s2    <= dprod_c[42:27];
			xr_s2   <= xr_s1;
			xv_s2   <= xv_s1;
			yv_s2   <= yv_s1;
			neg_s2  <= neg_s1;
			ypos_s2 <= ypos_s1;
			org_s2  <= org_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	logic                  v_s3, kind_s3, neg_s3, ypos_s3, org_s3;
	logic [31:0]           bu_s3;
	logic [XRW-1:0]        xr_s3;
	logic signed [CW:0]    xv_s3, yv_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_s2;
			bu_s3   <= p_s2 + 32'(d_s2);
			xr_s3   <= xr_s2;
			xv_s3   <= xv_s2;
			yv_s3   <= yv_s2;
			neg_s3  <= neg_s2;
			ypos_s3 <= ypos_s2;
			org_s3  <= org_s2;
		end
	end

	// ------------------------------------------- stage 4 and CORDIC stages
	// Index 0 holds the starting vector; index i+1 holds it after rotation i.
	logic signed [RW-1:0] cx_s [ITERATIONS+1];
	logic signed [RW-1:0] cy_s [ITERATIONS+1];
	logic signed [ZW-1:0] cz_s [ITERATIONS+1];
	logic                 ck_s [ITERATIONS+1];
	logic                 co_s [ITERATIONS+1];
	logic                 cv_s [ITERATIONS+1];

	logic                 flip_c;
	logic signed [ZW-1:0] bu_e_c, za_c, zv_c;
	logic signed [RW-1:0] xr_e_c, xa_c, xv_e_c, yv_e_c;

	always_comb begin
		bu_e_c = signed'({2'b00, bu_s3});
		// Angles beyond a quarter turn either way are folded by a half turn.
		flip_c = (bu_s3 > prc_pkg::BA_QUARTER) && (bu_s3 < prc_pkg::BA_3QUARTER);
		if (flip_c) begin
			za_c = bu_e_c - prc_pkg::Z_HALF_TURN;
		end else if (bu_s3[31]) begin
			za_c = bu_e_c - prc_pkg::Z_FULL_TURN;
		end else begin
			za_c = bu_e_c;
		end
		xr_e_c = signed'(RW'(xr_s3));
		xa_c   = flip_c ? -xr_e_c : xr_e_c;
		xv_e_c = RW'(xv_s3) <<< prc_pkg::VEC_FRAC;
		yv_e_c = RW'(yv_s3) <<< prc_pkg::VEC_FRAC;
		if (!neg_s3) begin
			zv_c = '0;
		end else if (ypos_s3) begin
			zv_c = prc_pkg::Z_HALF_TURN;
		end else begin
			zv_c = -prc_pkg::Z_HALF_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ck_s[0] <= kind_s3;
			co_s[0] <= org_s3;
			if (kind_s3) begin
				cx_s[0] <= xv_e_c;
				cy_s[0] <= yv_e_c;
				cz_s[0] <= zv_c;
			end else begin
				cx_s[0] <= xa_c;
				cy_s[0] <= '0;
				cz_s[0] <= za_c;
			end
		end
	end

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
		localparam int unsigned K = i % 32;
		logic signed [RW-1:0] xs, ys;
		logic signed [ZW-1:0] at;
		logic                 ccw;

		assign xs  = cx_s[i] >>> K;
		assign ys  = cy_s[i] >>> K;
		assign at  = signed'(ZW'(prc_pkg::atan_f(5'(K))));
		// Rotation follows the residual angle; vectoring drives y to zero.
		assign ccw = ck_s[i] ? cy_s[i][RW-1] : !cz_s[i][ZW-1];

		always_ff @(posedge clk) begin
			if (en) begin
				ck_s[i+1] <= ck_s[i];
				co_s[i+1] <= co_s[i];
				if (ccw) begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - at;
				end else begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + at;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_s[i+1] <= cv_s[i];
			end
		end
	end

	// ------------------------------------------- output stage 1: magnitudes
	logic                 v_o1, kind_o1, org_o1, sx_o1, sy_o1, xpos_o1, zneg_o1;
	logic [RW-1:0]        ax_o1, ay_o1;
	logic [53:0]          mlo_o1;
	logic [MHPW-1:0]      mhi_o1;
	logic [48:0]          aprod_o1;

	logic signed [RW-1:0] xl_c, yl_c;
	logic signed [ZW-1:0] zl_c, zabs_c;

	always_comb begin
		xl_c   = cx_s[ITERATIONS];
		yl_c   = cy_s[ITERATIONS];
		zl_c   = cz_s[ITERATIONS];
		zabs_c = zl_c[ZW-1] ? -zl_c : zl_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_o1  <= ck_s[ITERATIONS];
			org_o1   <= co_s[ITERATIONS];
			sx_o1    <= xl_c[RW-1];
			sy_o1    <= yl_c[RW-1];
			ax_o1    <= xl_c[RW-1] ? RW'(-xl_c) : RW'(xl_c);
			ay_o1    <= yl_c[RW-1] ? RW'(-yl_c) : RW'(yl_c);
			xpos_o1  <= !xl_c[RW-1] && (xl_c != '0);
			// The gain correction is split in two partial products.
			mlo_o1   <= 54'(xl_c[23:0]) * 54'(prc_pkg::INV_GAIN_Q30);
			mhi_o1   <= MHPW'(xl_c[MHW+23:24]) * MHPW'(prc_pkg::INV_GAIN_Q30);
			zneg_o1  <= zl_c[ZW-1];
			aprod_o1 <= 49'(zabs_c[ZW-2:0]) * 49'(prc_pkg::TURN_MUL);
		end
	end

	// ------------------------------------------- output stage 2: rounding
	logic                 v_o2, kind_o2, org_o2, sx_o2, sy_o2;
	logic [QW-1:0]        qx_o2, qy_o2;
	logic [CW-1:0]        mag_o2;
	logic [AOW-1:0]       ang_o2;

	logic [RW:0]          rx_c, ry_c;
	logic [54:0]          mlo_r_c;
	logic [MSW-1:0]       msum_c;
	logic [CW+4:0]        mfull_c;
	logic [CW-1:0]        mag_c;
	logic [49:0]          ar_c;
	logic [17:0]          aq_c;
	logic [AOW-1:0]       amag_c;

	always_comb begin
		rx_c    = {1'b0, ax_o1} + (RW+1)'(prc_pkg::RND_Q30);
		ry_c    = {1'b0, ay_o1} + (RW+1)'(prc_pkg::RND_Q30);
		mlo_r_c = 55'(mlo_o1) + prc_pkg::MAG_RND;
		msum_c  = MSW'(mhi_o1) + MSW'(mlo_r_c[54:24]);
		mfull_c = msum_c[MSW-1:22];
		if (!xpos_o1) begin
			mag_c = '0;
		end else if (mfull_c[CW+4:CW] != '0) begin
			mag_c = '1;
		end else begin
			mag_c = mfull_c[CW-1:0];
		end
		ar_c = 50'(aprod_o1) + prc_pkg::ANG_RND;
		aq_c = ar_c[49:32];
		if (aq_c > 18'(prc_pkg::HALF_TURN_DEG7)) begin
			amag_c = AOW'(prc_pkg::HALF_TURN_DEG7);
		end else begin
			amag_c = aq_c[AOW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_o2 <= kind_o1;
			org_o2  <= org_o1;
			sx_o2   <= sx_o1;
			sy_o2   <= sy_o1;
			qx_o2   <= rx_c[RW:30];
			qy_o2   <= ry_c[RW:30];
			mag_o2  <= mag_c;
			ang_o2  <= zneg_o1 ? -amag_c : amag_c;
		end
	end

	// ------------------------------------------- output register
	logic                 out_valid_q, kind_q;
	logic signed [CW-1:0] x_q, y_q;
	logic [CW-1:0]        mag_q;
	logic signed [AOW-1:0] ang_q;

	logic [CW-1:0]        xo_c, yo_c;

	always_comb begin
		if (!sx_o2) begin
			xo_c = (qx_o2 > Q_POS_MAX) ? C_POS_MAX : qx_o2[CW-1:0];
		end else begin
			xo_c = (qx_o2 >= Q_NEG_MAX) ? C_NEG_MAX : -qx_o2[CW-1:0];
		end
		if (!sy_o2) begin
			yo_c = (qy_o2 > Q_POS_MAX) ? C_POS_MAX : qy_o2[CW-1:0];
		end else begin
			yo_c = (qy_o2 >= Q_NEG_MAX) ? C_NEG_MAX : -qy_o2[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= kind_o2;
			if (!kind_o2) begin
				x_q   <= xo_c;
				y_q   <= yo_c;
				mag_q <= '0;
				ang_q <= '0;
			end else begin
				// The origin has no defined angle; both polar results read zero.
				x_q   <= '0;
				y_q   <= '0;
				mag_q <= org_o2 ? '0 : mag_o2;
				ang_q <= org_o2 ? '0 : ang_o2;
			end
		end
	end

	// ------------------------------------------- valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			cv_s[0]     <= 1'b0;
			v_o1        <= 1'b0;
			v_o2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (en) begin
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				cv_s[0]     <= v_s3;
				v_o1        <= cv_s[ITERATIONS];
				v_o2        <= v_o1;
				out_valid_q <= v_o2;
			end
		end
	end

	// The pipeline moves as one whenever the output register is free or drained.
	assign en = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign x_out         = x_q;
	assign y_out         = y_q;
	assign magnitude_out = mag_q;
	assign angle_out     = ang_q;

	// ------------------------------------------- assertions
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(v_o2) && $stable(cv_s[ITERATIONS]))
		else $error("pipeline moved while the output was stalled");

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> v_o2 == $past(v_o1))
		else $error("valid bit lost or repeated between output stages");

	a_input_taken: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transfer did not enter the first stage");

	a_kind0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind_q |-> magnitude_out == '0 && angle_out == '0)
		else $error("polar result fields not zero for a rectangular result");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_out <= 16'sd23040 && angle_out >= -16'sd23040)
		else $error("angle result beyond a half turn");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for polar_rect_converter: a table of corner cases, then random traffic.
// Depends on prc_pkg for the angle port widths; expected results come from a bit-true predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int COORD_WIDTH = 16;
	localparam int ITERATIONS  = 16;

	localparam bit KIND_TO_RECT  = 1'b0;
	localparam bit KIND_TO_POLAR = 1'b1;

	localparam int RANDOM_ITEMS = 1925;
	localparam int FLUSH_CYCLES = ITERATIONS + 7 + 16;
	localparam int CYCLE_LIMIT  = 750000;

	localparam longint TURN_DEG7      = 46080;
	localparam longint HALF_TURN_DEG7 = 23040;
	localparam longint BA_QUARTER     = 64'sd1 << 30;
	localparam longint BA_HALF        = 64'sd1 << 31;
	localparam longint BA_TURN        = 64'sd1 << 32;
	localparam longint INV_GAIN_Q30   = 652032874;
	localparam longint VEC_SCALE      = 65536;
	localparam longint COORD_MAX      = 32767;
	localparam longint COORD_MIN      = -32768;
	localparam longint MAG_MAX        = 65535;

	typedef struct packed {
		logic                                  kind;
		logic signed [COORD_WIDTH-1:0]         x;
		logic signed [COORD_WIDTH-1:0]         y;
		logic        [COORD_WIDTH-2:0]         magnitude;
		logic signed [prc_pkg::ANGLE_IN_W-1:0] angle;
	} conv_req_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0]          x;
		logic signed [COORD_WIDTH-1:0]          y;
		logic        [COORD_WIDTH-1:0]          magnitude;
		logic signed [prc_pkg::ANGLE_OUT_W-1:0] angle;
	} conv_result_t;

	typedef struct packed {
		conv_req_t    req;
		logic         known;
		conv_result_t result;
	} corner_row_t;

	logic                                   clk;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_ready;
	logic                                   kind;
	logic signed [COORD_WIDTH-1:0]          x_in;
	logic signed [COORD_WIDTH-1:0]          y_in;
	logic        [COORD_WIDTH-2:0]          magnitude_in;
	logic signed [prc_pkg::ANGLE_IN_W-1:0]  angle_in;
	logic                                   out_valid;
	logic                                   out_ready;
	logic signed [COORD_WIDTH-1:0]          x_out;
	logic signed [COORD_WIDTH-1:0]          y_out;
	logic        [COORD_WIDTH-1:0]          magnitude_out;
	logic signed [prc_pkg::ANGLE_OUT_W-1:0] angle_out;

	conv_result_t pending_results [$];
	int unsigned  fail_count = 0;
	int unsigned  cycle_count = 0;
	bit           steady = 1'b0;

	// atan(2^-i) in binary angle units, 2^32 per turn.
	longint atan_ba [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	// Rows with a typed result are the ones whose answer is plain zero.
	corner_row_t corner_rows [25] = '{
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd0, 17'sd0}, 1'b1, '0},
		'{'{KIND_TO_RECT, 16'shffff, 16'shffff, 15'd0, 17'sd23040}, 1'b1, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, 17'sd11520}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, 17'sd23040}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, -17'sd23040}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, -17'sd11520}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, 17'sd46079}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, -17'sd46079}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, 17'sh0ffff}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd32767, 17'sh10000}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sh7fff, 16'sh8000, 15'd1, 17'sd5760}, 1'b0, '0},
		'{'{KIND_TO_RECT, 16'sd0, 16'sd0, 15'd16384, 17'sd34560}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'sd0, 16'sd0, 15'd0, 17'sd0}, 1'b1, '0},
		'{'{KIND_TO_POLAR, 16'sd0, 16'sd0, 15'd32767, 17'sd46079}, 1'b1, '0},
		'{'{KIND_TO_POLAR, 16'sh7fff, 16'sd0, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'sh8000, 16'sd0, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'sh8000, 16'sh8000, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'sh7fff, 16'sh7fff, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'sd0, 16'sh7fff, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'sd0, 16'sh8000, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'shffff, 16'sd1, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'shffff, 16'shffff, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, 16'sd1, 16'sd0, 15'd0, 17'sd0}, 1'b0, '0},
		'{'{KIND_TO_POLAR, -16'sd7, 16'sd0, 15'd0, 17'sd0}, 1'b0, '0}
	};

	polar_rect_converter #(
		.COORD_WIDTH(COORD_WIDTH),
		.ITERATIONS (ITERATIONS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.x_in         (x_in),
		.y_in         (y_in),
		.magnitude_in (magnitude_in),
		.angle_in     (angle_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.x_out        (x_out),
		.y_out        (y_out),
		.magnitude_out(magnitude_out),
		.angle_out    (angle_out)
	);

	function automatic longint round_q30(input longint v);
		longint m;
		longint q;
		m = (v < 0) ? -v : v;
		q = (m + (64'sd1 << 29)) >>> 30;
		if (v < 0)
			q = -q;
		if (q > COORD_MAX)
			q = COORD_MAX;
		if (q < COORD_MIN)
			q = COORD_MIN;
		return q;
	endfunction

	function automatic longint ba_to_deg7(input longint z);
		longint m;
		longint q;
		m = (z < 0) ? -z : z;
		q = (m * TURN_DEG7 + BA_HALF) >>> 32;
		if (z < 0)
			q = -q;
		if (q > HALF_TURN_DEG7)
			q = HALF_TURN_DEG7;
		if (q < -HALF_TURN_DEG7)
			q = -HALF_TURN_DEG7;
		return q;
	endfunction

	function automatic conv_result_t predict_conversion(input conv_req_t req);
		conv_result_t      res;
		longint            x;
		longint            y;
		longint            z;
		longint            xs;
		longint            ys;
		longint            t;
		longint unsigned   ux;
		longint unsigned   prod;
		int                i;
		res = '0;
		if (req.kind == KIND_TO_RECT) begin
			// Map degrees to a binary angle, then fold into the right half plane.
			t = (longint'(req.angle) + 2 * TURN_DEG7) % TURN_DEG7;
			z = ((t << 32) + HALF_TURN_DEG7) / TURN_DEG7;
			x = longint'(req.magnitude) * INV_GAIN_Q30;
			y = 0;
			if (z >= BA_HALF)
				z -= BA_TURN;
			if (z > BA_QUARTER) begin
				z -= BA_HALF;
				x = -x;
			end else if (z < -BA_QUARTER) begin
				z += BA_HALF;
				x = -x;
			end
			for (i = 0; i < ITERATIONS; i++) begin
				xs = x >>> (i % 32);
				ys = y >>> (i % 32);
				if (z >= 0) begin
					x -= ys;
					y += xs;
					z -= atan_ba[i % 32];
				end else begin
					x += ys;
					y -= xs;
					z += atan_ba[i % 32];
				end
			end
			t = round_q30(x);
			res.x = t[COORD_WIDTH-1:0];
			t = round_q30(y);
			res.y = t[COORD_WIDTH-1:0];
		end else begin
			x = longint'(req.x);
			y = longint'(req.y);
			if (x != 0 || y != 0) begin
				z = 0;
				// Points left of the y axis are turned by a half turn first.
				if (x < 0) begin
					z = (y >= 0) ? BA_HALF : -BA_HALF;
					x = -x;
					y = -y;
				end
				x = x * VEC_SCALE;
				y = y * VEC_SCALE;
				for (i = 0; i < ITERATIONS; i++) begin
					xs = x >>> (i % 32);
					ys = y >>> (i % 32);
					if (y >= 0) begin
						x += ys;
						y -= xs;
						z += atan_ba[i % 32];
					end else begin
						x -= ys;
						y += xs;
						z -= atan_ba[i % 32];
					end
				end
				if (x > 0) begin
					ux = x;
					prod = (ux * 64'd652032874 + (64'd1 << 45)) >> 46;
					if (prod > MAG_MAX)
						prod = MAG_MAX;
					res.magnitude = prod[COORD_WIDTH-1:0];
				end
				t = ba_to_deg7(z);
				res.angle = t[prc_pkg::ANGLE_OUT_W-1:0];
			end
		end
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 10);
		return $urandom_range(16, 48);
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] random_coord();
		int unsigned sel;
		logic [31:0] rnd;
		int          near;
		sel = $urandom_range(0, 99);
		rnd = $urandom();
		near = int'($urandom_range(0, 32)) - 16;
		if (sel < 8)
			return '0;
		if (sel < 18)
			return near[COORD_WIDTH-1:0];
		if (sel < 24)
			return rnd[0] ? 16'sh7fff : 16'sh8000;
		return rnd[COORD_WIDTH-1:0];
	endfunction

	function automatic conv_req_t random_request();
		conv_req_t   req;
		int unsigned sel;
		logic [31:0] rnd;
		int          a;
		int unsigned m;
		rnd = $urandom();
		req.kind = rnd[0];
		req.x = random_coord();
		req.y = random_coord();
		sel = $urandom_range(0, 99);
		if (sel < 10)
			m = $urandom_range(0, 15);
		else if (sel < 20)
			m = 32767 - $urandom_range(0, 15);
		else
			m = $urandom();
		req.magnitude = m[COORD_WIDTH-2:0];
		sel = $urandom_range(0, 99);
		if (sel < 3)
			a = $urandom();
		else if (sel < 15)
			a = (int'($urandom_range(0, 16)) - 8) * 5760 + int'($urandom_range(0, 2)) - 1;
		else
			a = int'($urandom_range(0, 92158)) - 46079;
		req.angle = a[prc_pkg::ANGLE_IN_W-1:0];
		return req;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input conv_req_t req, input logic known, input conv_result_t fixed);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind = req.kind;
		x_in = req.x;
		y_in = req.y;
		magnitude_in = req.magnitude;
		angle_in = req.angle;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(known ? fixed : predict_conversion(req));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	function automatic void compare_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("polar_rect_converter regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		conv_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with none pending: x_out %0d y_out %0d magnitude_out %0d angle_out %0d",
					x_out, y_out, magnitude_out, angle_out);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("x_out", want.x, x_out);
				compare_field("y_out", want.y, y_out);
				compare_field("magnitude_out", {1'b0, want.magnitude}, {1'b0, magnitude_out});
				compare_field("angle_out", want.angle, angle_out);
			end
		end
	end

	// Receiver side: random stalls, none during the steady stretch.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : pick_gap();
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TO_RECT;
		x_in = '0;
		y_in = '0;
		magnitude_in = '0;
		angle_in = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (corner_rows[i])
			send_item(corner_rows[i].req, corner_rows[i].known, corner_rows[i].result);
		wait_drained();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 600 && n < 800);
			// Let the pipeline empty out now and then before the next transfer.
			if (n % 500 == 499)
				wait_drained();
			send_item(random_request(), 1'b0, '0);
		end
		wait_drained();
		repeat (FLUSH_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("polar_rect_converter regression: pass");
		else
			$display("polar_rect_converter regression: fail");
		$finish;
	end

endmodule
